// ===== rtl/core/mmlc_pkg.sv =====
package mmlc_pkg;

    localparam int unsigned OUT_W   = 16;
    localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

    localparam logic [7:0] CHAR_MARK  = 8'h31;  // '1'
    localparam logic [7:0] CHAR_SPACE = 8'h30;  // '0'

    typedef enum logic [1:0] {
        EVENT_DOT   = 2'd0,
        EVENT_DASH  = 2'd1,
        EVENT_CALIB = 2'd2
    } event_kind_t;

    typedef struct packed {
        event_kind_t      kind;
        logic [OUT_W-1:0] mark_len;
        logic [OUT_W-1:0] thr;
    } result_t;

endpackage

// ===== rtl/core/mmlc_div.sv =====
module mmlc_div #(
    parameter int unsigned Q_W     = 16,
    parameter int unsigned DIVISOR = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    output logic [Q_W-1:0] quotient
);

    localparam int unsigned REM_W = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
    localparam logic [REM_W-1:0] REM_LAST = REM_W'(DIVISOR - 1);

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quot_reg, quot_next;

    // hold a running total as quotient and remainder by DIVISOR; each step adds one
    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (step) begin
            if (rem_reg == REM_LAST) begin
                rem_next  = '0;
                quot_next = quot_reg + Q_W'(1);
            end else begin
                rem_next = rem_reg + REM_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            quot_reg <= '0;
        end else begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quotient = quot_reg;

`ifndef ASSERT_OFF
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= REM_LAST)
        else $error("remainder reached the divisor");

    a_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && rem_reg == REM_LAST) |=>
            (rem_reg == '0 && quot_reg == $past(quot_reg) + Q_W'(1)))
        else $error("quotient did not advance on remainder wrap");

    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> ($stable(rem_reg) && $stable(quot_reg)))
        else $error("running quotient moved without a step");
`endif

endmodule

// ===== rtl/core/morse_mark_length_classifier.sv =====
// Channel  Direction  Handshake          Payload
// -------  ---------  -----------------  ---------------------------------------------
// s_       in         s_valid / s_ready  s_sample_char[7:0]
// m_       out        m_valid / m_ready  m_event_kind[1:0], m_mark_length[15:0],
//                                        m_threshold_value[15:0]
//
// One sample word is taken per cycle while s_ready is high; each run's result is registered.
// The calibration average is kept as a running quotient and remainder, advanced on every
// counted mark, so the threshold is ready at the run that closes calibration: no stall.
// Reset (aresetn low, synchronous) restarts calibration and empties the output stage.
// A two-word output stage (output register plus skid) keeps s_ready high while one result
// waits on m_ready; s_ready drops only when both words are held.
module morse_mark_length_classifier
    import mmlc_pkg::*;
#(
    parameter int unsigned CALIB_RUNS  = 4,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_sample_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [15:0] m_mark_length,
    output logic [15:0] m_threshold_value
);

    localparam int unsigned RC_W  = $clog2(CALIB_RUNS + 1);
    localparam int unsigned EXT_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

    // run tracking and calibration state
    logic                   calibrating_reg, calibrating_next;
    logic                   mark_seen_reg, mark_seen_next;
    logic [COUNT_WIDTH-1:0] run_count_reg, run_count_next;
    logic [RC_W-1:0]        runs_collected_reg, runs_collected_next;
    logic [COUNT_WIDTH-1:0] threshold_reg, threshold_next;

    // output register and skid stage
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;
    logic                   skid_valid_reg, skid_valid_next;
    result_t                skid_reg, skid_next;

    logic                   accept;
    logic                   mark_in;
    logic                   run_end;
    logic                   calib_step;
    logic                   push;
    result_t                push_data;
    logic                   pop;
    logic [COUNT_WIDTH-1:0] calib_quot;

    // saturate a count to the 16-bit output field
    function automatic logic [OUT_W-1:0] clip_out(input logic [COUNT_WIDTH-1:0] v);
        logic [EXT_W-1:0] v_ext;
        v_ext = EXT_W'(v);
        if (v_ext > EXT_W'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return v_ext[OUT_W-1:0];
    endfunction

    // hold input while both output words are full
    assign s_ready = !skid_valid_reg;

    assign accept  = s_valid && s_ready;
    assign mark_in = accept && (s_sample_char == CHAR_MARK);
    assign run_end = accept && (s_sample_char == CHAR_SPACE) && mark_seen_reg;
    assign pop     = out_valid_reg && m_ready;

    // every mark that lengthens a calibration run adds one to the running total of the average
    assign calib_step = mark_in && calibrating_reg
                        && (run_count_reg != {COUNT_WIDTH{1'b1}});

    always_comb begin
        calibrating_next    = calibrating_reg;
        mark_seen_next      = mark_seen_reg;
        run_count_next      = run_count_reg;
        runs_collected_next = runs_collected_reg;
        threshold_next      = threshold_reg;
        push                = 1'b0;
        push_data.kind      = EVENT_DOT;
        push_data.mark_len  = clip_out(run_count_reg);
        push_data.thr       = clip_out(threshold_reg);

        // advance the run on a mark, saturating
        if (mark_in) begin
            if (run_count_reg != {COUNT_WIDTH{1'b1}}) begin
                run_count_next = run_count_reg + COUNT_WIDTH'(1);
            end
            mark_seen_next = 1'b1;
        end

        if (run_end) begin
            run_count_next = '0;
            mark_seen_next = 1'b0;
            if (calibrating_reg) begin
                runs_collected_next = runs_collected_reg + RC_W'(1);
                if (runs_collected_reg == RC_W'(CALIB_RUNS - 1)) begin
                    // last calibration run: latch the average and report it
                    calibrating_next = 1'b0;
                    threshold_next   = calib_quot;
                    push             = 1'b1;
                    push_data.kind   = EVENT_CALIB;
                    push_data.thr    = clip_out(calib_quot);
                end
            end else begin
                // compare on the full-width values, not the clipped ones
                push           = 1'b1;
                push_data.kind = (run_count_reg > threshold_reg) ? EVENT_DASH : EVENT_DOT;
            end
        end
    end

    // output register with skid; a push only arrives while the skid is empty
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg) begin
            if (push) begin
                out_valid_next = 1'b1;
                out_next       = push_data;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_next = push_data;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calibrating_reg    <= 1'b1;
            mark_seen_reg      <= 1'b0;
            run_count_reg      <= '0;
            runs_collected_reg <= '0;
            threshold_reg      <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end else begin
            calibrating_reg    <= calibrating_next;
            mark_seen_reg      <= mark_seen_next;
            run_count_reg      <= run_count_next;
            runs_collected_reg <= runs_collected_next;
            threshold_reg      <= threshold_next;
            out_valid_reg      <= out_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // threshold = truncated average of the calibration runs
    mmlc_div #(
        .Q_W     (COUNT_WIDTH),
        .DIVISOR (CALIB_RUNS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (calib_step),
        .quotient (calib_quot)
    );

    assign m_valid           = out_valid_reg;
    assign m_event_kind      = out_reg.kind;
    assign m_mark_length     = out_reg.mark_len;
    assign m_threshold_value = out_reg.thr;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with output register empty");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("result pushed with both output words full");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_event_kind)
            && $stable(m_mark_length) && $stable(m_threshold_value)))
        else $error("result word changed while waiting");

    a_calib_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_kind == EVENT_CALIB) |-> !calibrating_reg)
        else $error("calibration reported while still calibrating");

    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_kind == EVENT_DOT || m_event_kind == EVENT_DASH
                     || m_event_kind == EVENT_CALIB))
        else $error("result word carries an unknown event kind");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import mmlc_pkg::*;

    localparam int unsigned CALIB_RUNS   = 4;
    localparam int unsigned COUNT_WIDTH  = 16;
    localparam int unsigned RANDOM_WORDS = 1800;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned TAIL_CYCLES  = 4 * (COUNT_WIDTH + 8);

    localparam logic [COUNT_WIDTH-1:0] RUN_MAX = '1;

    typedef struct {
        logic [7:0] ch;
        bit         quiet;  // no idling on either side while this word is out
        bit         drain;  // hold this word back until no result is outstanding
        bit         hold;   // make the receiver stall for a long stretch
    } sample_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_sample_char = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_kind;
    logic [15:0] m_mark_length;
    logic [15:0] m_threshold_value;

    // stimulus and expectations
    sample_word_t sample_words[$];
    result_t      pending_events[$];

    // generator controls
    bit          gen_quiet;
    bit          gen_drain;
    bit          gen_hold;
    int unsigned live_words;

    // shadow state of the classifier
    bit                     calibrating  = 1'b1;
    bit                     mark_pending = 1'b0;
    logic [COUNT_WIDTH-1:0] run_len      = '0;
    int unsigned            calib_runs   = 0;
    logic [COUNT_WIDTH+4:0] calib_sum    = '0;
    logic [COUNT_WIDTH-1:0] thr_full     = '0;

    // handshake pacing
    int unsigned src_gap;
    int unsigned sink_gap;
    int unsigned hold_left;
    logic        hold_kick   = 1'b0;
    logic        quiet_phase = 1'b0;

    // bookkeeping
    int unsigned mismatches;
    int unsigned words_sent;
    int unsigned dots_seen;
    int unsigned dashes_seen;
    int unsigned calib_seen;
    int unsigned longest_mark;
    int unsigned cycle_count;
    int unsigned cycle_limit = 32'hFFFF_FFFF;

    morse_mark_length_classifier #(
        .CALIB_RUNS  (CALIB_RUNS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample_char     (s_sample_char),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_mark_length     (m_mark_length),
        .m_threshold_value (m_threshold_value)
    );

    always #4 aclk = ~aclk;

    // Clip a full-width count to the 16-bit output fields.
    function automatic logic [OUT_W-1:0] sat16(input logic [COUNT_WIDTH-1:0] v);
        return (v > OUT_MAX) ? OUT_MAX : OUT_W'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Advance the shadow classifier by one accepted word and queue any event it yields.
    task automatic classify_sample(input logic [7:0] ch);
        logic [COUNT_WIDTH-1:0] len;
        result_t                ev;
        if (ch == CHAR_MARK) begin
            if (run_len != RUN_MAX) begin
                run_len++;
            end
            mark_pending = 1'b1;
        end else if (ch == CHAR_SPACE && mark_pending) begin
            len = run_len;
            run_len = '0;
            mark_pending = 1'b0;
            if (calibrating) begin
                calib_sum += len;
                calib_runs++;
                if (calib_runs == CALIB_RUNS) begin
                    // the last calibration run fixes the threshold and reports it
                    thr_full = COUNT_WIDTH'(calib_sum / CALIB_RUNS);
                    calibrating = 1'b0;
                    ev.kind = EVENT_CALIB;
                    ev.mark_len = sat16(len);
                    ev.thr = sat16(thr_full);
                    pending_events.push_back(ev);
                end
            end else begin
                // compare on full widths, clip only for the output
                if (len > thr_full) begin
                    ev.kind = EVENT_DASH;
                end else begin
                    ev.kind = EVENT_DOT;
                end
                ev.mark_len = sat16(len);
                ev.thr = sat16(thr_full);
                pending_events.push_back(ev);
            end
        end
    endtask

    task automatic queue_sample(input logic [7:0] ch);
        sample_word_t w;
        w.ch = ch;
        w.quiet = gen_quiet;
        w.drain = gen_drain;
        w.hold = gen_hold;
        sample_words.push_back(w);
        gen_drain = 1'b0;
        gen_hold = 1'b0;
        if (ch == CHAR_MARK || ch == CHAR_SPACE) begin
            live_words++;
        end
    endtask

    task automatic queue_run(input int unsigned marks, input bit with_noise);
        for (int unsigned i = 0; i < marks; i++) begin
            queue_sample(CHAR_MARK);
            // stray bytes inside a run must not break it
            if (with_noise && $urandom_range(0, 11) == 0) begin
                queue_sample(8'($urandom_range(0, 255)));
            end
        end
        queue_sample(CHAR_SPACE);
    endtask

    // Driver: offer words from the queue, predict on every accepted word.
    always @(posedge aclk) begin
        sample_word_t head;
        logic         nxt_valid;
        logic [7:0]   nxt_char;
        logic         nxt_kick;
        logic         nxt_quiet;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_sample_char <= 8'h00;
            hold_kick <= 1'b0;
            quiet_phase <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                classify_sample(s_sample_char);
                words_sent++;
            end
            // a word not yet taken stays on the bus unchanged
            nxt_valid = s_valid && !s_ready;
            nxt_char = s_sample_char;
            nxt_kick = 1'b0;
            nxt_quiet = quiet_phase;
            if (!nxt_valid) begin
                if (src_gap != 0) begin
                    src_gap--;
                end else if (sample_words.size() != 0) begin
                    head = sample_words[0];
                    if (head.drain && pending_events.size() != 0) begin
                        // pause until the block has handed back everything owed
                    end else if (!head.quiet && $urandom_range(0, 7) == 0) begin
                        src_gap = $urandom_range(0, 14);
                    end else begin
                        void'(sample_words.pop_front());
                        nxt_valid = 1'b1;
                        nxt_char = head.ch;
                        nxt_kick = head.hold;
                        nxt_quiet = head.quiet;
                    end
                end
            end
            s_valid <= nxt_valid;
            s_sample_char <= nxt_char;
            hold_kick <= nxt_kick;
            quiet_phase <= nxt_quiet;
        end
    end

    // Long receiver stall, counted here so the sender keeps pushing meanwhile.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each taken result against the oldest expectation, pace m_ready.
    always @(posedge aclk) begin
        result_t want;
        logic    rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with nothing expected: kind %0d len %0d thr %0d",
                        m_event_kind, m_mark_length, m_threshold_value));
                end else begin
                    want = pending_events.pop_front();
                    if (m_event_kind !== want.kind) begin
                        report_mismatch($sformatf("event_kind %0d, expected %0d",
                                                  m_event_kind, want.kind));
                    end
                    if (m_mark_length !== want.mark_len) begin
                        report_mismatch($sformatf("mark_length %0d, expected %0d",
                                                  m_mark_length, want.mark_len));
                    end
                    if (m_threshold_value !== want.thr) begin
                        report_mismatch($sformatf("threshold_value %0d, expected %0d",
                                                  m_threshold_value, want.thr));
                    end
                    case (want.kind)
                        EVENT_DOT:   dots_seen++;
                        EVENT_DASH:  dashes_seen++;
                        default:     calib_seen++;
                    endcase
                    if (want.mark_len > longest_mark) begin
                        longest_mark = want.mark_len;
                    end
                end
            end
            if (hold_left != 0) begin
                rdy = 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                rdy = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 14);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_ready <= rdy;
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned pick;
        int unsigned chunk_mark;
        bit          chunk_quiet;
        bit          did_hold;
        bit          did_drain;

        // Directed opening: stray bytes, a space with no mark pending, then the
        // calibration runs 2, 3, 2, 4 (threshold 11/4 truncated to 2), with a
        // stray byte inside the second run, then one dot and one dash around it.
        queue_sample(8'h00);
        queue_sample(8'hFF);
        queue_sample(CHAR_SPACE);
        queue_run(2, 1'b0);
        queue_sample(CHAR_MARK);
        queue_sample(8'hB1);
        queue_sample(CHAR_MARK);
        queue_sample(CHAR_MARK);
        queue_sample(CHAR_SPACE);
        queue_run(2, 1'b0);
        queue_run(4, 1'b0);
        queue_run(2, 1'b0);
        queue_run(3, 1'b0);

        // Random part: mostly clean runs with random length, some noise and broken runs.
        chunk_mark = 0;
        chunk_quiet = 1'b0;
        did_hold = 1'b0;
        did_drain = 1'b0;
        while (live_words < RANDOM_WORDS) begin
            if (live_words >= chunk_mark) begin
                chunk_mark = live_words + 150;
                chunk_quiet = ($urandom_range(0, 3) == 0);
            end
            gen_quiet = chunk_quiet || (live_words > RANDOM_WORDS * 9 / 10);
            if (!did_hold && live_words >= 400) begin
                // stall the receiver while the sender keeps the input full
                did_hold = 1'b1;
                gen_hold = 1'b1;
                chunk_mark = live_words + 250;
                chunk_quiet = 1'b1;
                gen_quiet = 1'b1;
            end
            if (!did_drain && live_words >= 900) begin
                did_drain = 1'b1;
                gen_drain = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                queue_sample(8'($urandom_range(0, 255)));
            end else if (pick == 1) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 2))
                        0:       queue_sample(CHAR_MARK);
                        1:       queue_sample(CHAR_SPACE);
                        default: queue_sample(8'($urandom_range(0, 255)));
                    endcase
                end
            end else begin
                if ($urandom_range(0, 15) == 0) begin
                    queue_run($urandom_range(9, 40), 1'b1);
                end else begin
                    queue_run($urandom_range(1, 8), 1'b1);
                end
                if ($urandom_range(0, 3) == 0) begin
                    queue_sample(CHAR_SPACE);
                end
            end
        end

        cycle_limit = 64 * sample_words.size() + 50000;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // sample at the falling edge, clear of the clocked processes
        do begin
            @(negedge aclk);
        end while (sample_words.size() != 0 || s_valid || pending_events.size() != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (pending_events.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_events.size()));
        end

        $display("covered %0d sample words: %0d dots, %0d dashes, %0d calibration events",
                 words_sent, dots_seen, dashes_seen, calib_seen);
        $display("threshold %0d, longest reported mark %0d, receiver stall %0d cycles",
                 thr_full, longest_mark, HOLD_CYCLES);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mmlc_pkg.sv
rtl/core/mmlc_div.sv
rtl/core/morse_mark_length_classifier.sv
dv/testbench.sv
